FILE: src/taylor_polynomial_evaluator_core_defines.svh
// Assertion macros for the Taylor evaluator checker.
// Needs nothing else; include by bare file name.
`ifndef TAYLOR_POLYNOMIAL_EVALUATOR_CORE_DEFINES_SVH
`define TAYLOR_POLYNOMIAL_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tpe check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tpe check failed");

`endif

FILE: src/tpe_pkg.sv
// Shared types, microcode codes and Q-format helpers for the Taylor evaluator.
// No dependencies.
`default_nettype none

package tpe_pkg;

	localparam int unsigned MaxTermsDef = 64;
	localparam int unsigned FracBitsDef = 20;
	localparam int unsigned DataW       = 32;

	typedef logic signed [DataW-1:0] q_t;

	// Microprogram addresses
	typedef logic [2:0] upc_t;
	localparam upc_t UPC_IDLE  = 3'd0;
	localparam upc_t UPC_FIRST = 3'd1;
	localparam upc_t UPC_PWR   = 3'd2;
	localparam upc_t UPC_RCP   = 3'd3;
	localparam upc_t UPC_COEF  = 3'd4;
	localparam upc_t UPC_ACC   = 3'd5;
	localparam upc_t UPC_SKIP  = 3'd6;

	typedef enum logic [1:0] {A_POWER, A_PROD, A_COEF} mul_a_t;
	typedef enum logic [1:0] {B_DELTA, B_RECIP, B_PROD} mul_b_t;
	typedef enum logic [1:0] {NX_DISPATCH, NX_NEXT, NX_DONE} next_t;

	typedef struct packed {
		mul_a_t mul_a;
		mul_b_t mul_b;
		logic   mul_en;
		logic   ld_first;
		logic   ld_power;
		logic   acc;
		logic   fin;
		next_t  nxt;
	} uword_t;

	typedef struct packed {
		logic idx_zero;
		logic idx_below_max;
		logic hold;
	} dp_status_t;

	function automatic q_t sat_q(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return $signed(v[DataW-1:0]);
	endfunction

	// Round to nearest, ties up, then saturate.
	function automatic q_t rnd_sat(input logic signed [63:0] p, input int unsigned frac);
		logic signed [63:0] half;
		logic signed [63:0] r;
		half = 64'sd1 <<< (frac - 1);
		r = (p + half) >>> frac;
		return sat_q(r);
	endfunction

	// Sine series coefficients 0, +1, 0, -1 by term phase.
	function automatic q_t sine_coef(input logic [1:0] ph, input int unsigned frac);
		q_t one;
		one = q_t'(64'sd1 <<< frac);
		case (ph)
			2'd1: return one;
			2'd3: return -one;
			default: return '0;
		endcase
	endfunction

endpackage

`default_nettype wire

FILE: src/taylor_polynomial_evaluator_core.sv
// Taylor polynomial evaluator: one coefficient per transaction, Q format sum.
// Steps: a first term is accepted, then loaded; a later term is accepted, makes three passes
// through the one shared 32x32 multiplier, then accumulated; a term past MAX_TERMS is skipped.
// Throughput: one term in flight at a time, so a new term is taken once the last step is done.
// A result shows on value in the cycle after its final step and may wait while the next is taken.
// Reset (arst_n low, async) clears sequencer, sum, delta, index, sine_mode, out_valid; power=1.
`default_nettype none

module taylor_polynomial_evaluator_core #(
	parameter int unsigned MAX_TERMS = tpe_pkg::MaxTermsDef,
	parameter int unsigned FRAC_BITS = tpe_pkg::FracBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration: sine_mode register
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	// term input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] coefficient,
	input  logic signed [31:0] point,
	input  logic signed [31:0] center,
	input  logic               last_term,
	// result output
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value
);

	tpe_pkg::upc_t       pc;
	tpe_pkg::uword_t     uw;
	tpe_pkg::dp_status_t status;
	logic                accept;

	// Control store: fetch the word for the current step
	tpe_ucode_rom u_rom (
		.pc (pc),
		.uw (uw)
	);

	// Step counter: dispatch on the term index at accept, advance through the
	// multiply steps, return to idle once the final step completes
	tpe_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.uw       (uw),
		.status   (status),
		.pc       (pc),
		.in_ready (in_ready),
		.accept   (accept)
	);

	// Datapath: term recurrence power*delta*recip(i), then coefficient
	// product accumulated with saturation; the last term pushes the sum out
	tpe_datapath #(
		.MAX_TERMS (MAX_TERMS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.coefficient (coefficient),
		.point       (point),
		.center      (center),
		.last_term   (last_term),
		.uw          (uw),
		.status      (status),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.value       (value)
	);

endmodule

`default_nettype wire

FILE: src/tpe_ucode_rom.sv
// Read-only control store: one control word per microprogram step.
// Depends on tpe_pkg.
`default_nettype none

module tpe_ucode_rom (
	input  tpe_pkg::upc_t   pc,
	output tpe_pkg::uword_t uw
);

	always_comb begin
		uw = '{mul_a: tpe_pkg::A_POWER, mul_b: tpe_pkg::B_DELTA, mul_en: 1'b0,
			ld_first: 1'b0, ld_power: 1'b0, acc: 1'b0, fin: 1'b0,
			nxt: tpe_pkg::NX_DISPATCH};
		case (pc)
			tpe_pkg::UPC_IDLE: begin
				uw.nxt = tpe_pkg::NX_DISPATCH;
			end
			tpe_pkg::UPC_FIRST: begin
				uw.ld_first = 1'b1;
				uw.fin      = 1'b1;
				uw.nxt      = tpe_pkg::NX_DONE;
			end
			tpe_pkg::UPC_PWR: begin
				uw.mul_en = 1'b1;
				uw.mul_a  = tpe_pkg::A_POWER;
				uw.mul_b  = tpe_pkg::B_DELTA;
				uw.nxt    = tpe_pkg::NX_NEXT;
			end
			tpe_pkg::UPC_RCP: begin
				uw.mul_en = 1'b1;
				uw.mul_a  = tpe_pkg::A_PROD;
				uw.mul_b  = tpe_pkg::B_RECIP;
				uw.nxt    = tpe_pkg::NX_NEXT;
			end
			tpe_pkg::UPC_COEF: begin
				uw.mul_en   = 1'b1;
				uw.mul_a    = tpe_pkg::A_COEF;
				uw.mul_b    = tpe_pkg::B_PROD;
				uw.ld_power = 1'b1;
				uw.nxt      = tpe_pkg::NX_NEXT;
			end
			tpe_pkg::UPC_ACC: begin
				uw.acc = 1'b1;
				uw.fin = 1'b1;
				uw.nxt = tpe_pkg::NX_DONE;
			end
			tpe_pkg::UPC_SKIP: begin
				uw.fin = 1'b1;
				uw.nxt = tpe_pkg::NX_DONE;
			end
			default: begin
				uw.nxt = tpe_pkg::NX_DISPATCH;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/tpe_sequencer.sv
// Microprogram counter with dispatch and done jumps; owns the input handshake.
// Depends on tpe_pkg.
`default_nettype none

module tpe_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  tpe_pkg::uword_t     uw,
	input  tpe_pkg::dp_status_t status,
	output tpe_pkg::upc_t       pc,
	output logic                in_ready,
	output logic                accept
);

	tpe_pkg::upc_t pc_q;
	tpe_pkg::upc_t pc_d;

	assign pc       = pc_q;
	assign in_ready = (pc_q == tpe_pkg::UPC_IDLE);
	assign accept   = in_valid & in_ready;

	always_comb begin
		pc_d = pc_q;
		case (uw.nxt)
			tpe_pkg::NX_DISPATCH: begin
				if (accept) begin
					if (status.idx_zero) begin
						pc_d = tpe_pkg::UPC_FIRST;
					end else if (status.idx_below_max) begin
						pc_d = tpe_pkg::UPC_PWR;
					end else begin
						pc_d = tpe_pkg::UPC_SKIP;
					end
				end
			end
			tpe_pkg::NX_NEXT: begin
				pc_d = tpe_pkg::upc_t'(pc_q + 3'd1);
			end
			tpe_pkg::NX_DONE: begin
				// hold while the result cannot be handed over
				pc_d = status.hold ? pc_q : tpe_pkg::UPC_IDLE;
			end
			default: begin
				pc_d = tpe_pkg::UPC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= tpe_pkg::UPC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/tpe_datapath.sv
// Shared multiplier, term state, reciprocal table and output register.
// Depends on tpe_pkg.
`default_nettype none

module tpe_datapath #(
	parameter int unsigned MAX_TERMS = tpe_pkg::MaxTermsDef,
	parameter int unsigned FRAC_BITS = tpe_pkg::FracBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                accept,
	input  logic signed [31:0]  coefficient,
	input  logic signed [31:0]  point,
	input  logic signed [31:0]  center,
	input  logic                last_term,
	input  tpe_pkg::uword_t     uw,
	output tpe_pkg::dp_status_t status,
	input  logic                out_ready,
	output logic                out_valid,
	output logic signed [31:0]  value
);

	localparam int unsigned TidxW  = $clog2(MAX_TERMS + 1);
	localparam int unsigned RidxW  = $clog2(MAX_TERMS);
	localparam int unsigned RDepth = 2 ** RidxW;
	localparam tpe_pkg::q_t QOne   = tpe_pkg::q_t'(64'sd1 <<< FRAC_BITS);

	// Reciprocal table round(2^FRAC_BITS / i), built at elaboration
	tpe_pkg::q_t recip_tab [RDepth];

	for (genvar gi = 0; gi < RDepth; gi++) begin : g_recip
		if (gi == 0) begin : g_zero
			assign recip_tab[gi] = QOne;
		end else begin : g_ent
			localparam longint RVal = ((64'sd1 <<< FRAC_BITS) + gi / 2) / gi;
			assign recip_tab[gi] = tpe_pkg::q_t'(RVal);
		end
	end

	logic               sine_q;
	tpe_pkg::q_t        coef_q;
	tpe_pkg::q_t        diff_q;
	logic               last_q;
	tpe_pkg::q_t        delta_q;
	tpe_pkg::q_t        power_q;
	tpe_pkg::q_t        sum_q;
	logic [TidxW-1:0]   index_q;
	logic signed [63:0] prod_q;
	tpe_pkg::q_t        value_q;
	logic               out_valid_q;

	tpe_pkg::q_t        x0;
	tpe_pkg::q_t        coef_eff;
	tpe_pkg::q_t        prod_rs;
	tpe_pkg::q_t        mul_a;
	tpe_pkg::q_t        mul_b;
	logic signed [63:0] mul_p;
	tpe_pkg::q_t        acc_sum;
	tpe_pkg::q_t        next_sum;
	logic               hold;
	logic               go;
	logic               emit;

	assign x0       = sine_q ? '0 : center;
	assign coef_eff = sine_q ? tpe_pkg::sine_coef(index_q[1:0], FRAC_BITS) : coefficient;
	assign prod_rs  = tpe_pkg::rnd_sat(prod_q, FRAC_BITS);

	always_comb begin
		case (uw.mul_a)
			tpe_pkg::A_POWER: mul_a = power_q;
			tpe_pkg::A_PROD:  mul_a = prod_rs;
			tpe_pkg::A_COEF:  mul_a = coef_q;
			default:          mul_a = power_q;
		endcase
		case (uw.mul_b)
			tpe_pkg::B_DELTA: mul_b = delta_q;
			tpe_pkg::B_RECIP: mul_b = recip_tab[index_q[RidxW-1:0]];
			tpe_pkg::B_PROD:  mul_b = prod_rs;
			default:          mul_b = delta_q;
		endcase
	end

	assign mul_p   = 64'(mul_a) * 64'(mul_b);
	assign acc_sum = tpe_pkg::sat_q(64'(sum_q) + 64'(prod_rs));

	always_comb begin
		if (uw.ld_first) begin
			next_sum = coef_q;
		end else if (uw.acc) begin
			next_sum = acc_sum;
		end else begin
			next_sum = sum_q;
		end
	end

	assign hold = uw.fin & last_q & out_valid_q & ~out_ready;
	assign go   = uw.fin & ~hold;
	assign emit = go & last_q;

	assign status.idx_zero      = (index_q == '0);
	assign status.idx_below_max = (index_q < TidxW'(MAX_TERMS));
	assign status.hold          = hold;

	assign out_valid = out_valid_q;
	assign value     = value_q;

	// item capture, multiplier product and output value
	always_ff @(posedge clk) begin
		if (accept) begin
			coef_q <= coef_eff;
			diff_q <= tpe_pkg::sat_q(64'(point) - 64'(x0));
			last_q <= last_term;
		end
		if (uw.mul_en) begin
			prod_q <= mul_p;
		end
		if (emit) begin
			value_q <= next_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sine_q      <= 1'b0;
			delta_q     <= '0;
			power_q     <= QOne;
			sum_q       <= '0;
			index_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sine_q <= cfg_wr_data;
			end
			if (uw.ld_power) begin
				power_q <= prod_rs;
			end
			if (go) begin
				sum_q <= next_sum;
				if (uw.ld_first) begin
					delta_q <= diff_q;
				end
				if (last_q) begin
					index_q <= '0;
					power_q <= QOne;
				end else if (uw.ld_first) begin
					index_q <= TidxW'(1);
					power_q <= QOne;
				end else if (uw.acc) begin
					index_q <= TidxW'(index_q + 1'b1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/tpe_checker.sv
// Port-level checks for the Taylor evaluator, bound to the top level.
// Depends on taylor_polynomial_evaluator_core_defines.svh.
`default_nettype none
`include "taylor_polynomial_evaluator_core_defines.svh"

module tpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] value
);

	// a taken transaction leaves the block busy in the next cycle
	`TPE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// an idle block with nothing offered stays ready
	`TPE_ASSERT_NEXT(a_idle_stays_ready, clk, arst_n, in_ready && !in_valid, in_ready)

	// a result never appears straight after an accept
	`TPE_ASSERT_SAME(a_no_instant_result, clk, arst_n, $rose(out_valid),
		!$past(in_valid && in_ready))

	// a stalled result holds
	`TPE_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(value))

endmodule

bind taylor_polynomial_evaluator_core tpe_checker u_tpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value)
);

`default_nettype wire
